// ===== hdl/oled_page_framebuffer_flush_assert.svh =====
// assertion macros for the oled page frame buffer
`ifndef OLED_PAGE_FRAMEBUFFER_FLUSH_ASSERT_SVH
`define OLED_PAGE_FRAMEBUFFER_FLUSH_ASSERT_SVH

// same-cycle implication, disabled in reset
`define OFB_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled in reset
`define OFB_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hdl/ofb_pkg.sv =====
// shared types and constants for the oled page frame buffer
package ofb_pkg;

    localparam int unsigned BYTE_W   = 8;
    localparam int unsigned INIT_LEN = 23;

    localparam logic [7:0] CMD_PAGE   = 8'hB0;
    localparam logic [7:0] CMD_COL_HI = 8'h10;

    localparam logic [7:0] INIT_CMDS [INIT_LEN] = '{
        8'hAE, 8'hD5, 8'h80, 8'hA8, 8'h3F, 8'hD3, 8'h00, 8'h40,
        8'hAD, 8'h8B, 8'hA1, 8'hC8, 8'hDA, 8'h12, 8'h81, 8'h80,
        8'hD9, 8'h22, 8'hDB, 8'h40, 8'hA4, 8'hA6, 8'hAF
    };

    typedef enum logic [2:0] {
        REQ_PIXEL = 3'd0,
        REQ_BYTE  = 3'd1,
        REQ_CLEAR = 3'd2,
        REQ_FLUSH = 3'd3,
        REQ_INIT  = 3'd4,
        REQ_TICK  = 3'd5
    } t_req;

    typedef enum logic [4:0] {
        C_IDLE  = 5'b00001,
        C_EXEC  = 5'b00010,
        C_MOD   = 5'b00100,
        C_EMIT  = 5'b01000,
        C_CLEAR = 5'b10000
    } t_ctl_state;

    typedef enum logic [5:0] {
        PH_IDLE  = 6'b000001,
        PH_INIT  = 6'b000010,
        PH_PAGE  = 6'b000100,
        PH_COLLO = 6'b001000,
        PH_COLHI = 6'b010000,
        PH_DATA  = 6'b100000
    } t_phase;

endpackage

// ===== hdl/ofb_store.sv =====
// single-port frame store with registered read data
module ofb_store #(
    parameter int unsigned DEPTH = 1024,
    parameter int unsigned AW    = 10
) (
    input  logic                      i_clk,
    input  logic                      i_we,
    input  logic                      i_re,
    input  logic [AW-1:0]             i_addr,
    input  logic [ofb_pkg::BYTE_W-1:0] i_wdata,
    output logic [ofb_pkg::BYTE_W-1:0] o_rdata
);
    import ofb_pkg::*;

    logic [BYTE_W-1:0] r_mem [DEPTH];
    logic [BYTE_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_addr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== hdl/oled_page_framebuffer_flush.sv =====
// oled page frame buffer with dirty-page flush and init sequencer, top level
// a tick's result is registered by the execute state, a data byte's by the emit state after a store read
// a result is held in the output register until taken; a tick waits while it is full
// a new item is taken only in idle; pixel writes add a modify state, data-byte ticks an emit state (single-port store)
// clear buffer and start init (when no flush runs) sweep every store address, with no item taken
// reset: synchronous active low, followed by the same sweep; column offset returns to 2
module oled_page_framebuffer_flush #(
    parameter int unsigned PAGES   = 8,
    parameter int unsigned COLUMNS = 128
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [39:0] s_axis_tdata,  // row, column, pixel_on, page, byte_value, zero pad
    input  logic [2:0]  s_axis_tuser,  // req_type
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [7:0]  m_axis_tdata,  // out_byte
    output logic        m_axis_tuser,  // is_data
    output logic        m_axis_tlast,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [3:0]  i_cfg_data
);
    import ofb_pkg::*;

    localparam int unsigned DEPTH = PAGES * COLUMNS;
    localparam int unsigned AW    = $clog2(DEPTH);
    localparam int unsigned PW    = (PAGES > 1) ? $clog2(PAGES) : 1;
    localparam int unsigned CW    = $clog2(COLUMNS);
    localparam int unsigned CNTW  = (CW > 5) ? CW : 5;

    t_ctl_state        r_ctl, n_ctl;
    t_phase            r_phase, n_phase;
    logic [PAGES-1:0]  r_dirty, n_dirty;
    logic [PW-1:0]     r_page, n_page;
    logic [CNTW-1:0]   r_count, n_count;
    logic [AW-1:0]     r_clr_addr, n_clr_addr;
    logic [3:0]        r_col_off;

    logic [2:0]        r_req;
    logic [7:0]        r_row, r_col, r_pg, r_bval;
    logic              r_pix_on;

    logic              r_out_valid, n_out_valid;
    logic [7:0]        r_out_byte, n_out_byte;
    logic              r_out_data, n_out_data;
    logic              r_out_last, n_out_last;
    logic              out_load;

    logic              mem_we, mem_re;
    logic [AW-1:0]     mem_addr;
    logic [7:0]        mem_wdata, mem_rdata;

    logic              in_acc;
    logic [4:0]        pix_pg;
    logic              pix_ok, byte_ok;
    logic [AW-1:0]     pix_addr, byte_addr, data_addr;
    logic [7:0]        bit_mask;

    logic [PW:0]       bp_start;
    logic              bp_found;
    logic [PW-1:0]     bp_page;

    ofb_store #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_re    (mem_re),
        .i_addr  (mem_addr),
        .i_wdata (mem_wdata),
        .o_rdata (mem_rdata)
    );

    assign s_axis_tready = (r_ctl == C_IDLE);
    assign in_acc        = s_axis_tvalid && s_axis_tready;
    assign o_cfg_ready   = 1'b1;

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_byte;
    assign m_axis_tuser  = r_out_data;
    assign m_axis_tlast  = r_out_last;

    // address decode of the held item
    assign pix_pg    = r_row[7:3];
    assign pix_ok    = ({3'b000, pix_pg} < 8'(PAGES)) && ({1'b0, r_col} < 9'(COLUMNS));
    assign byte_ok   = ({1'b0, r_pg} < 9'(PAGES)) && ({1'b0, r_col} < 9'(COLUMNS));
    assign pix_addr  = AW'(pix_pg * COLUMNS) + AW'(r_col);
    assign byte_addr = AW'(r_pg * COLUMNS) + AW'(r_col);
    assign data_addr = AW'(r_page * COLUMNS) + AW'(r_count);
    assign bit_mask  = 8'b1 << r_row[2:0];

    // lowest dirty page at or above the start page
    assign bp_start = (r_ctl == C_EMIT) ? ({1'b0, r_page} + 1'b1) : '0;

    always_comb begin
        bp_found = 1'b0;
        bp_page  = '0;
        for (int p = PAGES - 1; p >= 0; p--) begin
            if ((p >= int'(bp_start)) && r_dirty[p]) begin
                bp_found = 1'b1;
                bp_page  = PW'(p);
            end
        end
    end

    always_comb begin
        n_ctl       = r_ctl;
        n_phase     = r_phase;
        n_dirty     = r_dirty;
        n_page      = r_page;
        n_count     = r_count;
        n_clr_addr  = r_clr_addr;
        n_out_byte  = r_out_byte;
        n_out_data  = r_out_data;
        n_out_last  = r_out_last;
        out_load    = 1'b0;
        mem_we      = 1'b0;
        mem_re      = 1'b0;
        mem_addr    = pix_addr;
        mem_wdata   = '0;

        case (r_ctl)
            C_CLEAR: begin
                mem_we   = 1'b1;
                mem_addr = r_clr_addr;
                if (r_clr_addr == AW'(DEPTH - 1)) begin
                    n_ctl = C_IDLE;
                end else begin
                    n_clr_addr = r_clr_addr + 1'b1;
                end
            end
            C_IDLE: begin
                if (in_acc) begin
                    n_ctl = C_EXEC;
                end
            end
            C_EXEC: begin
                n_ctl = C_IDLE;
                case (r_req)
                    REQ_PIXEL: begin
                        if (pix_ok) begin
                            mem_re = 1'b1;
                            n_ctl  = C_MOD;
                        end
                    end
                    REQ_BYTE: begin
                        if (byte_ok) begin
                            mem_we                = 1'b1;
                            mem_addr              = byte_addr;
                            mem_wdata             = r_bval;
                            n_dirty[r_pg[PW-1:0]] = 1'b1;
                        end
                    end
                    REQ_CLEAR: begin
                        n_clr_addr = '0;
                        n_ctl      = C_CLEAR;
                    end
                    REQ_FLUSH: begin
                        if (r_phase == PH_IDLE && bp_found) begin
                            n_phase = PH_PAGE;
                            n_page  = bp_page;
                        end
                    end
                    REQ_INIT: begin
                        if (r_phase == PH_IDLE) begin
                            n_dirty    = '1;
                            n_phase    = PH_INIT;
                            n_count    = '0;
                            n_clr_addr = '0;
                            n_ctl      = C_CLEAR;
                        end
                    end
                    REQ_TICK: begin
                        if (r_phase != PH_IDLE && r_out_valid) begin
                            n_ctl = C_EXEC;
                        end else begin
                            case (r_phase)
                                PH_INIT: begin
                                    out_load   = 1'b1;
                                    n_out_byte = INIT_CMDS[r_count[4:0]];
                                    n_out_data = 1'b0;
                                    n_out_last = (r_count == CNTW'(INIT_LEN - 1));
                                    if (r_count == CNTW'(INIT_LEN - 1)) begin
                                        n_count = '0;
                                        if (bp_found) begin
                                            n_phase = PH_PAGE;
                                            n_page  = bp_page;
                                        end else begin
                                            n_phase = PH_IDLE;
                                        end
                                    end else begin
                                        n_count = r_count + 1'b1;
                                    end
                                end
                                PH_PAGE: begin
                                    out_load         = 1'b1;
                                    n_out_byte       = CMD_PAGE | 8'(r_page);
                                    n_out_data       = 1'b0;
                                    n_out_last       = 1'b0;
                                    n_dirty[r_page]  = 1'b0;
                                    n_phase          = PH_COLLO;
                                end
                                PH_COLLO: begin
                                    out_load   = 1'b1;
                                    n_out_byte = {4'b0000, r_col_off};
                                    n_out_data = 1'b0;
                                    n_out_last = 1'b0;
                                    n_phase    = PH_COLHI;
                                end
                                PH_COLHI: begin
                                    out_load   = 1'b1;
                                    n_out_byte = CMD_COL_HI;
                                    n_out_data = 1'b0;
                                    n_out_last = 1'b0;
                                    n_phase    = PH_DATA;
                                    n_count    = '0;
                                end
                                PH_DATA: begin
                                    mem_re   = 1'b1;
                                    mem_addr = data_addr;
                                    n_ctl    = C_EMIT;
                                end
                                default: begin
                                    n_ctl = C_IDLE;
                                end
                            endcase
                        end
                    end
                    default: begin
                        n_ctl = C_IDLE;
                    end
                endcase
            end
            C_MOD: begin
                mem_we                 = 1'b1;
                mem_wdata              = r_pix_on ? (mem_rdata | bit_mask)
                                                  : (mem_rdata & ~bit_mask);
                n_dirty[pix_pg[PW-1:0]] = 1'b1;
                n_ctl                  = C_IDLE;
            end
            C_EMIT: begin
                out_load   = 1'b1;
                n_out_byte = mem_rdata;
                n_out_data = 1'b1;
                n_out_last = 1'b0;
                if (r_count == CNTW'(COLUMNS - 1)) begin
                    n_count = '0;
                    if (bp_found) begin
                        n_phase = PH_PAGE;
                        n_page  = bp_page;
                    end else begin
                        n_phase    = PH_IDLE;
                        n_out_last = 1'b1;
                    end
                end else begin
                    n_count = r_count + 1'b1;
                end
                n_ctl = C_IDLE;
            end
            default: begin
                n_ctl = C_IDLE;
            end
        endcase
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (out_load) begin
            n_out_valid = 1'b1;
        end else if (m_axis_tready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl       <= C_CLEAR;
            r_phase     <= PH_IDLE;
            r_dirty     <= '0;
            r_page      <= '0;
            r_count     <= '0;
            r_clr_addr  <= '0;
            r_col_off   <= 4'd2;
            r_out_valid <= 1'b0;
        end else begin
            r_ctl       <= n_ctl;
            r_phase     <= n_phase;
            r_dirty     <= n_dirty;
            r_page      <= n_page;
            r_count     <= n_count;
            r_clr_addr  <= n_clr_addr;
            r_out_valid <= n_out_valid;
            if (i_cfg_valid && o_cfg_ready) begin
                r_col_off <= i_cfg_data;
            end
        end
    end

    // item and result payload
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_req    <= s_axis_tuser;
            r_row    <= s_axis_tdata[7:0];
            r_col    <= s_axis_tdata[15:8];
            r_pix_on <= s_axis_tdata[16];
            r_pg     <= s_axis_tdata[24:17];
            r_bval   <= s_axis_tdata[32:25];
        end
        r_out_byte <= n_out_byte;
        r_out_data <= n_out_data;
        r_out_last <= n_out_last;
    end

`include "oled_page_framebuffer_flush_assert.svh"

    `OFB_ASSERT_NOW(a_out_free, out_load, !r_out_valid, "result loaded over a pending one")
    `OFB_ASSERT_NOW(a_emit_after_read, r_ctl == C_EMIT,
        $past(r_ctl) == C_EXEC && $past(r_phase) == PH_DATA, "data emit without store read")
    `OFB_ASSERT_NEXT(a_last_idle, out_load && n_out_last && n_out_data,
        r_phase == PH_IDLE, "flush end did not return to idle")

endmodule
